// ===== rtl/hhmm_pkg.sv =====
// ----------------------------------------------------------------------------
// hhmm_pkg
// Shared types, constants and the seven-segment decode of the HH:MM clock.
// ----------------------------------------------------------------------------
package hhmm_pkg;

    localparam int DIGIT_COUNT        = 4;
    localparam int SCAN_W             = $clog2(DIGIT_COUNT);
    localparam int SLOT_TICKS_DEFAULT = 255;
    localparam int LOCKOUT_W          = 14;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 14'd12750;
    localparam logic [7:0]           BRIGHT_RESET  = 8'd254;
    localparam logic [7:0]           BRIGHT_MAX    = 8'd255;
    localparam logic [7:0]           BRIGHT_MIN    = 8'd1;
    localparam logic [7:0]           SEG_BLANK     = 8'hff;
    localparam logic [7:0]           SEG_DP_MASK   = 8'h7f;

    localparam logic [SCAN_W-1:0] DIGIT_HOUR_TENS   = 2'd0;
    localparam logic [SCAN_W-1:0] DIGIT_HOUR_ONES   = 2'd1;
    localparam logic [SCAN_W-1:0] DIGIT_MINUTE_TENS = 2'd2;
    localparam logic [SCAN_W-1:0] DIGIT_MINUTE_ONES = 2'd3;

    localparam logic REG_LOCKOUT_TICKS = 1'b0;

    localparam logic [7:0] SEG_TABLE [10] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
    };

    typedef struct packed {
        logic advance_edge;
        logic bright_edge;
        logic advance_level;
        logic bright_level;
    } tick_t;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
    } time_t;

    function automatic logic [7:0] seg_decode(input logic [3:0] digit);
        logic [7:0] seg;
        if (digit <= 4'd9)
        begin
            seg = SEG_TABLE[digit];
        end
        else
        begin
            seg = SEG_BLANK;
        end
        return seg;
    endfunction

endpackage

// ===== rtl/hhmm_apb_regs.sv =====
// ----------------------------------------------------------------------------
// hhmm_apb_regs
// APB register file holding the advance button lockout length.
// ----------------------------------------------------------------------------
module hhmm_apb_regs
    import hhmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LOCKOUT_W-1:0]  lockout_ticks
);

    logic [LOCKOUT_W-1:0] lockout_reg;
    logic [LOCKOUT_W-1:0] lockout_next;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_LOCKOUT_TICKS);

    always_comb
    begin
        lockout_next = lockout_reg;
        if (wr_en)
        begin
            lockout_next = pwdata[LOCKOUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= LOCKOUT_RESET;
        end
        else
        begin
            lockout_reg <= lockout_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_LOCKOUT_TICKS)
        begin
            prdata = {{(APB_DATA_W-LOCKOUT_W){1'b0}}, lockout_reg};
        end
    end

    assign lockout_ticks = lockout_reg;

endmodule

// ===== rtl/hhmm_buttons.sv =====
// ----------------------------------------------------------------------------
// hhmm_buttons
// Arming of both buttons, lockout of the advance button, and the brightness level.
// ----------------------------------------------------------------------------
module hhmm_buttons
    import hhmm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  tick_t                tick,
    input  logic [LOCKOUT_W-1:0] lockout_ticks,
    output logic                 add_minute,
    output logic [7:0]           bright_next
);

    logic                 adv_armed_reg;
    logic                 adv_armed_next;
    logic                 brt_armed_reg;
    logic                 brt_armed_next;
    logic [LOCKOUT_W-1:0] count_reg;
    logic [LOCKOUT_W-1:0] count_next;
    logic [7:0]           bright_reg;
    logic [LOCKOUT_W-1:0] limit;
    logic [LOCKOUT_W-1:0] count_inc;
    logic                 adv_hit;
    logic                 brt_hit;

    assign adv_hit    = tick.advance_edge & adv_armed_reg;
    assign brt_hit    = tick.bright_edge & brt_armed_reg;
    assign add_minute = adv_hit;
    assign limit      = (lockout_ticks == '0) ? LOCKOUT_W'(1) : lockout_ticks;
    assign count_inc  = count_reg + LOCKOUT_W'(1);

    always_comb
    begin
        adv_armed_next = adv_armed_reg & ~adv_hit;
        count_next     = count_reg;
        if (!adv_armed_next && tick.advance_level)
        begin
            if (count_inc >= limit)
            begin
                adv_armed_next = 1'b1;
                count_next     = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_comb
    begin
        brt_armed_next = (brt_armed_reg & ~brt_hit) | tick.bright_level;
        bright_next    = bright_reg;
        if (brt_hit)
        begin
            bright_next = (bright_reg == BRIGHT_MAX) ? BRIGHT_MIN : bright_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adv_armed_reg <= 1'b1;
            brt_armed_reg <= 1'b1;
            count_reg     <= '0;
            bright_reg    <= BRIGHT_RESET;
        end
        else if (step)
        begin
            adv_armed_reg <= adv_armed_next;
            brt_armed_reg <= brt_armed_next;
            count_reg     <= count_next;
            bright_reg    <= bright_next;
        end
    end

endmodule

// ===== rtl/hhmm_time_counter.sv =====
// ----------------------------------------------------------------------------
// hhmm_time_counter
// BCD hours and minutes count that wraps from 23:59 to 00:00.
// ----------------------------------------------------------------------------
module hhmm_time_counter
    import hhmm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  logic  add_minute,
    output time_t time_next
);

    time_t      time_reg;
    logic [4:0] mo;
    logic [3:0] mt;
    logic [4:0] ho;
    logic [2:0] ht;

    always_comb
    begin
        mo = {1'b0, time_reg.minute_ones};
        mt = {1'b0, time_reg.minute_tens};
        ho = {1'b0, time_reg.hour_ones};
        ht = {1'b0, time_reg.hour_tens};
        if (add_minute)
        begin
            mo = mo + 5'd1;
            if (mo >= 5'd10)
            begin
                mo = '0;
                mt = mt + 4'd1;
            end
            if (mt >= 4'd6)
            begin
                mt = '0;
                mo = '0;
                ho = ho + 5'd1;
            end
            if (ho >= 5'd10)
            begin
                ho = '0;
                ht = ht + 3'd1;
            end
            if (ht >= 3'd2 && ho >= 5'd4)
            begin
                ht = '0;
                ho = '0;
                mt = '0;
                mo = '0;
            end
        end
        time_next.hour_tens   = ht[1:0];
        time_next.hour_ones   = ho[3:0];
        time_next.minute_tens = mt[2:0];
        time_next.minute_ones = mo[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (step)
        begin
            time_reg <= time_next;
        end
    end

endmodule

// ===== rtl/hhmm_scan_decode.sv =====
// ----------------------------------------------------------------------------
// hhmm_scan_decode
// Digit scan position, slot timing and seven-segment decode.
// ----------------------------------------------------------------------------
module hhmm_scan_decode
    import hhmm_pkg::*;
#(
    parameter int SLOT_TICKS = SLOT_TICKS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  time_t      time_now,
    input  logic [7:0] bright_now,
    output logic [7:0] segments,
    output logic [3:0] digit_enables
);

    logic [7:0]        phase_reg;
    logic [7:0]        phase_next;
    logic [SCAN_W-1:0] scan_reg;
    logic [SCAN_W-1:0] scan_next;
    logic [8:0]        phase_inc;
    logic [3:0]        digit_val;
    logic [7:0]        seg;

    assign phase_inc = {1'b0, phase_reg} + 9'd1;

    always_comb
    begin
        phase_next = phase_inc[7:0];
        scan_next  = scan_reg;
        if (phase_inc >= 9'(SLOT_TICKS))
        begin
            phase_next = '0;
            scan_next  = scan_reg + SCAN_W'(1);
        end
    end

    always_comb
    begin
        case (scan_reg)
            DIGIT_HOUR_TENS:   digit_val = {2'b00, time_now.hour_tens};
            DIGIT_HOUR_ONES:   digit_val = time_now.hour_ones;
            DIGIT_MINUTE_TENS: digit_val = {1'b0, time_now.minute_tens};
            default:           digit_val = time_now.minute_ones;
        endcase
        seg = seg_decode(digit_val);
        if (scan_reg == DIGIT_HOUR_ONES)
        begin
            seg = seg & SEG_DP_MASK;
        end
        segments = seg;
        if (phase_reg < bright_now)
        begin
            digit_enables = ~(4'b0001 << scan_reg);
        end
        else
        begin
            digit_enables = 4'hf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            scan_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            scan_reg  <= scan_next;
        end
    end

endmodule

// ===== rtl/hhmm_clock_seven_segment_driver_top.sv =====
// ----------------------------------------------------------------------------
// hhmm_clock_seven_segment_driver_top
// Button-set HH:MM clock driving a multiplexed four-digit common-anode display.
// ----------------------------------------------------------------------------
// Each input transaction is one tick and produces exactly one output
// transaction. A tick passes through an input register and a result register
// with combinational logic between them, so ticks are taken one per clock
// cycle while the output is not stalled, and a tick's result is registered
// once the output is free. The lockout length is set through the APB port at
// byte address 0 and should only be changed while no transaction is in flight.
// ----------------------------------------------------------------------------
module hhmm_clock_seven_segment_driver_top
    import hhmm_pkg::*;
#(
    parameter int SLOT_TICKS = SLOT_TICKS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  advance_edge,
    input  logic                  bright_edge,
    input  logic                  advance_level,
    input  logic                  bright_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            segments,
    output logic [3:0]            digit_enables,
    output logic [1:0]            hour_tens,
    output logic [3:0]            hour_ones,
    output logic [2:0]            minute_tens,
    output logic [3:0]            minute_ones,
    output logic [7:0]            brightness,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    tick_t                tick_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           segments_reg;
    logic [3:0]           enables_reg;
    time_t                time_out_reg;
    logic [7:0]           bright_out_reg;
    logic                 step;
    logic                 in_accept;
    logic [LOCKOUT_W-1:0] lockout_ticks;
    logic                 add_minute;
    logic [7:0]           bright_next;
    time_t                time_next;
    logic [7:0]           seg_now;
    logic [3:0]           en_now;

    assign step           = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall       = in_valid_reg & ~step;
    assign in_accept      = in_valid & ~in_stall;
    assign in_valid_next  = in_accept | (in_valid_reg & ~step);
    assign out_valid_next = step | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tick_reg.advance_edge  <= advance_edge;
            tick_reg.bright_edge   <= bright_edge;
            tick_reg.advance_level <= advance_level;
            tick_reg.bright_level  <= bright_level;
        end
        if (step)
        begin
            segments_reg   <= seg_now;
            enables_reg    <= en_now;
            time_out_reg   <= time_next;
            bright_out_reg <= bright_next;
        end
    end

    hhmm_apb_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .lockout_ticks (lockout_ticks)
    );

    hhmm_buttons u_buttons
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .tick          (tick_reg),
        .lockout_ticks (lockout_ticks),
        .add_minute    (add_minute),
        .bright_next   (bright_next)
    );

    hhmm_time_counter u_time
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .add_minute (add_minute),
        .time_next  (time_next)
    );

    hhmm_scan_decode #(
        .SLOT_TICKS (SLOT_TICKS)
    ) u_scan
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .time_now      (time_next),
        .bright_now    (bright_next),
        .segments      (seg_now),
        .digit_enables (en_now)
    );

    assign out_valid     = out_valid_reg;
    assign segments      = segments_reg;
    assign digit_enables = enables_reg;
    assign hour_tens     = time_out_reg.hour_tens;
    assign hour_ones     = time_out_reg.hour_ones;
    assign minute_tens   = time_out_reg.minute_tens;
    assign minute_ones   = time_out_reg.minute_ones;
    assign brightness    = bright_out_reg;

endmodule

// ===== tb/sv/hhmm_readout_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hhmm_readout_checker
// Watches the tick and readout channels and the APB writes of the HH:MM clock,
// predicts the display readout of every accepted tick and compares it, field
// by field, with the readout that the block delivers.
// ----------------------------------------------------------------------------
module hhmm_readout_checker
    import hhmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  advance_edge,
    input  logic                  bright_edge,
    input  logic                  advance_level,
    input  logic                  bright_level,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [7:0]            segments,
    input  logic [3:0]            digit_enables,
    input  logic [1:0]            hour_tens,
    input  logic [3:0]            hour_ones,
    input  logic [2:0]            minute_tens,
    input  logic [3:0]            minute_ones,
    input  logic [7:0]            brightness,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    pending,
    output int                    errors
);

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_enables;
        time_t      shown;
        logic [7:0] brightness;
    } readout_t;

    localparam logic [APB_ADDR_W-1:0] LOCKOUT_ADDR = APB_ADDR_W'(4 * REG_LOCKOUT_TICKS);

    localparam logic [7:0] GLYPH [10] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
    };

    readout_t             readout_q [$];
    logic [LOCKOUT_W-1:0] lockout     = LOCKOUT_RESET;
    time_t                clock_time  = '0;
    logic [7:0]           bright      = 8'd254;
    logic                 adv_armed   = 1'b1;
    logic                 brt_armed   = 1'b1;
    logic [LOCKOUT_W-1:0] lock_count  = '0;
    logic [SCAN_W-1:0]    scan        = '0;
    logic [7:0]           phase       = '0;
    int                   checked     = 0;
    int                   outstanding = 0;
    int                   failures    = 0;

    assign pending = outstanding;
    assign errors  = failures;

    function automatic readout_t next_readout(input tick_t t);
        readout_t   r;
        logic [3:0] digit;
        int         limit;
        if (t.advance_edge && adv_armed)
        begin
            adv_armed = 1'b0;
            clock_time.minute_ones = clock_time.minute_ones + 4'd1;
            if (clock_time.minute_ones >= 4'd10)
            begin
                clock_time.minute_ones = 4'd0;
                clock_time.minute_tens = clock_time.minute_tens + 3'd1;
            end
            if (clock_time.minute_tens >= 3'd6)
            begin
                clock_time.minute_tens = 3'd0;
                clock_time.minute_ones = 4'd0;
                clock_time.hour_ones   = clock_time.hour_ones + 4'd1;
            end
            if (clock_time.hour_ones >= 4'd10)
            begin
                clock_time.hour_ones = 4'd0;
                clock_time.hour_tens = clock_time.hour_tens + 2'd1;
            end
            if (clock_time.hour_tens >= 2'd2 && clock_time.hour_ones >= 4'd4)
            begin
                clock_time = '0;
            end
        end
        if (t.bright_edge && brt_armed)
        begin
            brt_armed = 1'b0;
            if (bright == 8'd255)
            begin
                bright = 8'd0;
            end
            bright = bright + 8'd1;
        end
        if (!adv_armed && t.advance_level)
        begin
            limit = (lockout == '0) ? 1 : int'(lockout);
            lock_count = lock_count + 1'b1;
            if (int'(lock_count) >= limit)
            begin
                adv_armed  = 1'b1;
                lock_count = '0;
            end
        end
        if (!brt_armed && t.bright_level)
        begin
            brt_armed = 1'b1;
        end

        case (scan)
            DIGIT_HOUR_TENS:   digit = {2'b00, clock_time.hour_tens};
            DIGIT_HOUR_ONES:   digit = clock_time.hour_ones;
            DIGIT_MINUTE_TENS: digit = {1'b0, clock_time.minute_tens};
            default:           digit = clock_time.minute_ones;
        endcase
        r.segments = (digit <= 4'd9) ? GLYPH[digit] : 8'hff;
        if (scan == DIGIT_HOUR_ONES)
        begin
            r.segments[7] = 1'b0;
        end
        r.digit_enables = (phase < bright) ? ~(4'b0001 << scan) : 4'hf;
        r.shown         = clock_time;
        r.brightness    = bright;

        if (int'(phase) + 1 >= SLOT_TICKS_DEFAULT)
        begin
            phase = '0;
            scan  = scan + 1'b1;
        end
        else
        begin
            phase = phase + 8'd1;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("readout %0d: %s expected %0h, got %0h", checked, field, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        readout_t want;
        if (!rst_n)
        begin
            readout_q.delete();
            lockout     = LOCKOUT_RESET;
            clock_time  = '0;
            bright      = 8'd254;
            adv_armed   = 1'b1;
            brt_armed   = 1'b1;
            lock_count  = '0;
            scan        = '0;
            phase       = '0;
            outstanding = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                readout_q.push_back(next_readout(tick_t'({advance_edge, bright_edge,
                                                          advance_level, bright_level})));
            end
            if (psel && penable && pwrite && pready && paddr == LOCKOUT_ADDR)
            begin
                lockout = pwdata[LOCKOUT_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                checked++;
                if (readout_q.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("readout %0d arrived with no tick waiting for it", checked);
                    end
                end
                else
                begin
                    want = readout_q.pop_front();
                    check_field("segments", segments, want.segments);
                    check_field("digit_enables", 8'(digit_enables), 8'(want.digit_enables));
                    check_field("hour_tens", 8'(hour_tens), 8'(want.shown.hour_tens));
                    check_field("hour_ones", 8'(hour_ones), 8'(want.shown.hour_ones));
                    check_field("minute_tens", 8'(minute_tens), 8'(want.shown.minute_tens));
                    check_field("minute_ones", 8'(minute_ones), 8'(want.shown.minute_ones));
                    check_field("brightness", brightness, want.brightness);
                end
            end
            outstanding = readout_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives ticks and lockout settings into the HH:MM clock and gives the verdict.
// ----------------------------------------------------------------------------
// A short directed sequence covers both buttons, edges while disarmed, the
// brightness wrap and lockout values of zero, one and the maximum. Random
// phases follow with lowered lockout counts, mostly steady button presses so
// that the count runs past 23:59, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import hhmm_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES     = 6;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_MAX = '1;
    localparam logic [APB_ADDR_W-1:0] LOCKOUT_ADDR = APB_ADDR_W'(4 * REG_LOCKOUT_TICKS);

    localparam logic [LOCKOUT_W-1:0] PHASE_LOCKOUT [PHASES] = '{
        14'd1, LOCKOUT_MAX, 14'd3, 14'd0, 14'd40, 14'd1
    };
    localparam int PHASE_TICKS [PHASES] = '{760, 30, 40, 710, 30, 30};
    localparam bit PHASE_PRESSING [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    // Bits are advance_edge, bright_edge, advance_level, bright_level.
    localparam logic [3:0] OPENING [20] = '{
        4'b0000, 4'b1111, 4'b0100, 4'b0100, 4'b1000, 4'b0011, 4'b0111,
        4'b0010, 4'b1000, 4'b1010, 4'b1010,
        4'b1010, 4'b1010, 4'b0001,
        4'b1111, 4'b0011, 4'b1011, 4'b0110, 4'b0000, 4'b1101
    };

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  advance_edge  = 1'b0;
    logic                  bright_edge   = 1'b0;
    logic                  advance_level = 1'b0;
    logic                  bright_level  = 1'b0;
    logic                  out_stall     = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic [7:0]            segments;
    logic [3:0]            digit_enables;
    logic [1:0]            hour_tens;
    logic [3:0]            hour_ones;
    logic [2:0]            minute_tens;
    logic [3:0]            minute_ones;
    logic [7:0]            brightness;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    pending;
    int                    errors;
    int                    idle_cycles   = 0;
    bit                    steady        = 1'b0;

    hhmm_clock_seven_segment_driver_top uut (.*);

    hhmm_readout_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < 18);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic tick_t random_tick(input bit pressing);
        tick_t t;
        t = tick_t'($urandom_range(15));
        if (pressing)
        begin
            if ($urandom_range(127) != 0)
            begin
                t.advance_edge  = 1'b1;
                t.advance_level = 1'b1;
            end
        end
        else
        begin
            t.advance_edge  = ($urandom_range(3) == 0);
            t.advance_level = ($urandom_range(3) != 0);
            t.bright_level  = ($urandom_range(3) != 0);
        end
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        while (!steady && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        advance_edge  <= t.advance_edge;
        bright_edge   <= t.bright_edge;
        advance_level <= t.advance_level;
        bright_level  <= t.bright_level;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_for_readouts();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_lockout(input logic [LOCKOUT_W-1:0] ticks);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LOCKOUT_ADDR;
        pwdata  <= APB_DATA_W'(ticks);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING[i])
        begin
            if (i == 7 || i == 11 || i == 14)
            begin
                wait_for_readouts();
                write_lockout((i == 7) ? 14'd1 : (i == 11) ? 14'd0 : LOCKOUT_MAX);
            end
            send_tick(tick_t'(OPENING[i]));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_readouts();
            write_lockout(PHASE_LOCKOUT[p]);
            for (int n = 0; n < PHASE_TICKS[p]; n++)
            begin
                steady = (p == 0 && n >= 200 && n < 450);
                send_tick(random_tick(PHASE_PRESSING[p]));
            end
        end
        steady = 1'b0;

        wait_for_readouts();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
